// ===== rtl/vtc_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertex transform package
// Shared constants, types and helpers for the vertex transform, clip and
// viewport pipeline.
// ----------------------------------------------------------------------------
package vtc_pkg;

	// Fixed-point format of coefficients, coordinates and results.
	localparam int FRAC_BITS = 16;
	localparam int WORD_W    = 32;
	localparam int REG_W     = 13;

	// Clip coordinates keep the full sum of three products plus a translation.
	localparam int SUM_W  = 2 * WORD_W + 2;
	localparam int CLIP_W = SUM_W - FRAC_BITS;

	// Quotient of the perspective divide: one integer bit and the fraction.
	localparam int QUO_W = FRAC_BITS + 1;

	// Normalized coordinate plus one, and its product with a window size.
	localparam int NRM_W = FRAC_BITS + 2;
	localparam int SCR_W = NRM_W + REG_W;

	// Stream widths.
	localparam int IN_DATA_W  = 136;
	localparam int OUT_DATA_W = 96;

	// Input kinds carried on tuser.
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_XFRM = 1'b1;

	// Configuration register indexes.
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [REG_W-1:0] WIDTH_RESET  = REG_W'(640);
	localparam logic [REG_W-1:0] HEIGHT_RESET = REG_W'(480);

	// The stored 4x4 matrix, row times four plus column.
	typedef logic signed [WORD_W-1:0] mat_t [16];

	// One vertex waiting between the front and the back.
	typedef struct packed {
		logic signed [WORD_W-1:0] vx;
		logic signed [WORD_W-1:0] vy;
		logic signed [WORD_W-1:0] vz;
	} vert_t;

	// Status that the back reports to the front.
	typedef struct packed {
		logic busy;
		logic pop;
	} back_stat_t;

	// Saturate a non-negative value to the largest signed word.
	function automatic logic [WORD_W-1:0] sat_pos(input logic [63:0] v);
		logic [63:0] lim;
		lim = 64'((64'(1) << (WORD_W - 1)) - 64'(1));
		if (v > lim) begin
			sat_pos = lim[WORD_W-1:0];
		end else begin
			sat_pos = v[WORD_W-1:0];
		end
	endfunction

endpackage

// ===== rtl/vtc_front.sv =====
// ----------------------------------------------------------------------------
// Vertex transform front end
// Accepts input beats, writes matrix loads into the coefficient store and
// queues vertices for the back end.
// ----------------------------------------------------------------------------
module vtc_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic                             s_tuser,
	input  logic [vtc_pkg::IN_DATA_W-1:0]    s_tdata,
	output vtc_pkg::mat_t                    mat,
	output logic                             q_valid,
	output vtc_pkg::vert_t                   q_head,
	input  vtc_pkg::back_stat_t              stat
);
	import vtc_pkg::*;

	logic [1:0] cnt_q;
	logic       wr_q;
	logic       rd_q;
	vert_t      fifo_q [2];
	mat_t       mat_q;
	logic       push;
	logic       load;
	logic       pop;

	// A load waits until no vertex is queued or in flight, so every vertex
	// sees the matrix that stood when it was accepted.
	always_comb begin
		if (s_tuser == FUNC_XFRM) begin
			s_tready = (cnt_q != 2'd2);
		end else begin
			s_tready = (cnt_q == 2'd0) && !stat.busy;
		end
		push = s_tvalid && s_tready && (s_tuser == FUNC_XFRM);
		load = s_tvalid && s_tready && (s_tuser == FUNC_LOAD);
		pop  = stat.pop && (cnt_q != 2'd0);
	end

	// Coefficient store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				mat_q[i] <= '0;
			end
		end else if (load) begin
			mat_q[s_tdata[3:0]] <= s_tdata[35:4];
		end
	end

	// Two-entry vertex queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= '{vx: s_tdata[67:36], vy: s_tdata[99:68], vz: s_tdata[131:100]};
		end
	end

	assign mat     = mat_q;
	assign q_valid = (cnt_q != 2'd0);
	assign q_head  = fifo_q[rd_q];

endmodule

// ===== rtl/vtc_back.sv =====
// ----------------------------------------------------------------------------
// Vertex transform back end
// Matrix multiply, clip test, pipelined perspective divide, viewport scaling
// and the output register.
// ----------------------------------------------------------------------------
module vtc_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [vtc_pkg::REG_W-1:0]         cfg_data,
	input  vtc_pkg::mat_t                     mat,
	input  logic                              q_valid,
	input  vtc_pkg::vert_t                    q_head,
	output vtc_pkg::back_stat_t               stat,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic                              m_tuser,
	output logic [vtc_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import vtc_pkg::*;

	logic [REG_W-1:0] width_q;
	logic [REG_W-1:0] height_q;
	logic             adv;

	// Stage 1: products.
	logic                     val_s1;
	logic signed [2*WORD_W-1:0] prod_s1 [3][4];
	logic signed [WORD_W-1:0]   tr_s1 [4];
	// Stage 2: clip coordinates.
	logic                     val_s2;
	logic signed [CLIP_W-1:0] clip_s2 [4];
	// Stage 3: clip test and magnitudes.
	logic                     val_s3;
	logic                     vis_s3;
	logic [CLIP_W-1:0]        mag_s3 [3];
	logic                     neg_s3 [3];
	logic [CLIP_W-1:0]        w_s3;
	// Divider stages.
	logic                     val_d [FRAC_BITS+1];
	logic                     vis_d [FRAC_BITS+1];
	logic [CLIP_W-1:0]        rem_d [FRAC_BITS+1][3];
	logic [QUO_W-1:0]         quo_d [FRAC_BITS+1][3];
	logic                     neg_d [FRAC_BITS+1][3];
	logic [CLIP_W-1:0]        w_d   [FRAC_BITS+1];
	// Scaling stage.
	logic                     val_s4;
	logic                     vis_s4;
	logic [SCR_W-1:0]         scr_s4 [3];
	// Output register.
	logic                     out_valid_q;
	logic                     out_vis_q;
	logic [OUT_DATA_W-1:0]    out_data_q;

	// The whole pipeline moves whenever the output register can take a beat.
	assign adv = !out_valid_q || m_tready;

	always_comb begin
		stat.pop  = adv;
		stat.busy = val_s1 || val_s2 || val_s3 || val_s4 || out_valid_q;
		for (int k = 0; k <= FRAC_BITS; k++) begin
			if (val_d[k]) begin
				stat.busy = 1'b1;
			end
		end
	end

	// Window size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits of the fixed stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
			val_s2 <= 1'b0;
			val_s3 <= 1'b0;
			val_s4 <= 1'b0;
		end else if (adv) begin
			val_s1 <= q_valid;
			val_s2 <= val_s1;
			val_s3 <= val_s2;
			val_s4 <= val_d[FRAC_BITS];
		end
	end

	// Stage 1: twelve products of the vertex and the matrix.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 4; c++) begin
				prod_s1[0][c] <= q_head.vx * mat[c];
				prod_s1[1][c] <= q_head.vy * mat[4 + c];
				prod_s1[2][c] <= q_head.vz * mat[8 + c];
				tr_s1[c]      <= mat[12 + c];
			end
		end
	end

	// Stage 2: exact column sums, floored once to the fraction width.
	always_ff @(posedge clk) begin
		logic signed [SUM_W-1:0] acc;
		if (adv) begin
			for (int c = 0; c < 4; c++) begin
				acc = SUM_W'(prod_s1[0][c]) + SUM_W'(prod_s1[1][c])
					+ SUM_W'(prod_s1[2][c]) + (SUM_W'(tr_s1[c]) <<< FRAC_BITS);
				clip_s2[c] <= acc[SUM_W-1:FRAC_BITS];
			end
		end
	end

	// Stage 3: clip test, then signs and magnitudes for the divide.
	always_ff @(posedge clk) begin
		logic signed [CLIP_W:0] w;
		logic signed [CLIP_W:0] c;
		logic                   ok;
		if (adv) begin
			w  = (CLIP_W+1)'(clip_s2[3]);
			ok = (w > 0);
			for (int i = 0; i < 2; i++) begin
				c  = (CLIP_W+1)'(clip_s2[i]);
				ok = ok && (c >= -w) && (c <= w);
			end
			c  = (CLIP_W+1)'(clip_s2[2]);
			ok = ok && (c >= 0) && (c <= w);
			vis_s3 <= ok;
			w_s3   <= clip_s2[3];
			for (int i = 0; i < 3; i++) begin
				neg_s3[i] <= clip_s2[i][CLIP_W-1];
				mag_s3[i] <= clip_s2[i][CLIP_W-1] ? CLIP_W'(-clip_s2[i])
					: CLIP_W'(clip_s2[i]);
			end
		end
	end

	// Restoring divider, one quotient bit per stage for each coordinate.
	for (genvar k = 0; k <= FRAC_BITS; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				val_d[k] <= 1'b0;
			end else if (adv) begin
				val_d[k] <= (k == 0) ? val_s3 : val_d[(k == 0) ? 0 : k - 1];
			end
		end

		always_ff @(posedge clk) begin
			logic [CLIP_W:0]   rr;
			logic [CLIP_W:0]   wd;
			logic              ge;
			logic [CLIP_W-1:0] rin;
			logic [QUO_W-1:0]  qin;
			if (adv) begin
				if (k == 0) begin
					vis_d[k] <= vis_s3;
					w_d[k]   <= w_s3;
					wd = {1'b0, w_s3};
				end else begin
					vis_d[k] <= vis_d[(k == 0) ? 0 : k - 1];
					w_d[k]   <= w_d[(k == 0) ? 0 : k - 1];
					wd = {1'b0, w_d[(k == 0) ? 0 : k - 1]};
				end
				for (int i = 0; i < 3; i++) begin
					if (k == 0) begin
						rin = mag_s3[i];
						qin = '0;
						rr  = {1'b0, rin};
						neg_d[k][i] <= neg_s3[i];
					end else begin
						rin = rem_d[(k == 0) ? 0 : k - 1][i];
						qin = quo_d[(k == 0) ? 0 : k - 1][i];
						rr  = {rin, 1'b0};
						neg_d[k][i] <= neg_d[(k == 0) ? 0 : k - 1][i];
					end
					ge = (rr >= wd);
					rem_d[k][i] <= ge ? CLIP_W'(rr - wd) : CLIP_W'(rr);
					quo_d[k][i] <= {qin[QUO_W-2:0], ge};
				end
			end
		end
	end

	// Scaling stage: shift x and y into 0..2, multiply x by the width and y and z by the height.
	always_ff @(posedge clk) begin
		logic signed [NRM_W:0] n [3];
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				n[i] = neg_d[FRAC_BITS][i] ? -(NRM_W+1)'(quo_d[FRAC_BITS][i])
					: (NRM_W+1)'(quo_d[FRAC_BITS][i]);
			end
			n[0] = n[0] + ((NRM_W+1)'(1) <<< FRAC_BITS);
			n[1] = n[1] + ((NRM_W+1)'(1) <<< FRAC_BITS);
			vis_s4    <= vis_d[FRAC_BITS];
			scr_s4[0] <= n[0][NRM_W-1:0] * width_q;
			scr_s4[1] <= n[1][NRM_W-1:0] * height_q;
			scr_s4[2] <= n[2][NRM_W-1:0] * height_q;
		end
	end

	// Output register: saturate, and zero the fields of a clipped vertex.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= val_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_vis_q <= vis_s4;
			if (vis_s4) begin
				out_data_q <= {sat_pos(64'(scr_s4[2] >> 1)), sat_pos(64'(scr_s4[1] >> 2)),
					sat_pos(64'(scr_s4[0] >> 2))};
			end else begin
				out_data_q <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_vis_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== rtl/vertex_transform_clip_viewport.sv =====
// ----------------------------------------------------------------------------
// Vertex transform, clip and viewport
// Multiplies vertices by a stored 4x4 matrix, clip-tests them, divides by w
// and maps the result to screen coordinates.
// ----------------------------------------------------------------------------
// A vertex beat enters every cycle while the two-entry queue has room. It
// passes in order through the queue, the products, the column sums, the clip
// test, a stage of the pipelined divider for each quotient bit, the scaling
// and the output register; coordinates are Q16.16. The pipeline stalls as a
// whole only while a result waits on m_tready. A coefficient load is taken
// only when no vertex is queued or in flight, so it costs the drain time of
// the pipeline when it follows vertices.
module vertex_transform_clip_viewport (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration writes.
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [vtc_pkg::REG_W-1:0]         cfg_data,
	// Input beats.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic                              s_tuser,  // func
	input  logic [vtc_pkg::IN_DATA_W-1:0]     s_tdata,  // coef_index, coef_value, vx, vy, vz
	// Result beats.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic                              m_tuser,  // visible
	output logic [vtc_pkg::OUT_DATA_W-1:0]    m_tdata   // screen_x, screen_y, screen_z
);
	import vtc_pkg::*;

	mat_t       mat;
	logic       q_valid;
	vert_t      q_head;
	back_stat_t stat;

	vtc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.mat      (mat),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.stat     (stat)
	);

	vtc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mat       (mat),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata)
	);

endmodule
